FILE: hw/rtl/fspq_pkg.sv
// Shared types, constants and helpers of the frame slot present queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fspq_pkg;

  // Slot indexes wrap around the ring buffers, so the pool is a power of two.
  localparam int unsigned SLOTS    = 4;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned ID_WIDTH = 32;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [CNT_W-1:0]  SLOTS_C    = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);

  // Operation codes carried in the mode field.
  localparam logic [3:0] MODE_ACQUIRE   = 4'd0;
  localparam logic [3:0] MODE_PUSH      = 4'd1;
  localparam logic [3:0] MODE_RELEASE   = 4'd2;
  localparam logic [3:0] MODE_PRESENT   = 4'd3;
  localparam logic [3:0] MODE_CANDIDATE = 4'd4;
  localparam logic [3:0] MODE_REUSE     = 4'd5;
  localparam logic [3:0] MODE_COMMIT    = 4'd6;
  localparam logic [3:0] MODE_DEFER     = 4'd7;
  localparam logic [3:0] MODE_RESYNC    = 4'd8;
  localparam logic [3:0] MODE_FFWD      = 4'd9;
  localparam logic [3:0] MODE_CLEAR     = 4'd10;

  // Result status codes.
  localparam logic [1:0] STAT_SLOT    = 2'd0;
  localparam logic [1:0] STAT_NONE    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_LEGACY   = 3'd0;
  localparam logic [2:0] REG_STEAL    = 3'd1;
  localparam logic [2:0] REG_REUSE    = 3'd2;
  localparam logic [2:0] REG_OLDEST   = 3'd3;
  localparam logic [2:0] REG_DEADLINE = 3'd4;
  localparam logic [2:0] REG_KEEP     = 3'd5;
  localparam logic [2:0] REG_TRIMSKIP = 3'd6;
  localparam logic [2:0] REG_LIMIT    = 3'd7;

  typedef struct packed {
    logic [3:0]        mode;
    logic [SLOT_W-1:0] slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   out_slot;
    logic [ID_WIDTH-1:0] frame_id;
    logic                reused_previous;
    logic                stolen;
    logic [CNT_W-1:0]    dropped_count;
    logic [CNT_W-1:0]    skipped_count;
    logic [CNT_W-1:0]    backlog_depth;
  } out_word_t;

  typedef struct packed {
    logic               legacy_mode;
    logic               allow_steal;
    logic               allow_reuse;
    logic               prefer_oldest;
    logic               allow_deadline_drop;
    logic               keep_backlog;
    logic               trim_is_skip;
    logic [LIMIT_W-1:0] backlog_limit;
  } cfg_t;

  // Register values after reset: reuse allowed, backlog of one frame.
  localparam cfg_t CFG_RESET = '{
    legacy_mode:         1'b0,
    allow_steal:         1'b0,
    allow_reuse:         1'b1,
    prefer_oldest:       1'b0,
    allow_deadline_drop: 1'b0,
    keep_backlog:        1'b0,
    trim_is_skip:        1'b0,
    backlog_limit:       LIMIT_W'(1)
  };

  // One write port and one read port of a slot ring memory.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [14:0] {
    ST_INIT  = 15'b000000000000001,
    ST_IDLE  = 15'b000000000000010,
    ST_DEC   = 15'b000000000000100,
    ST_POPRD = 15'b000000000001000,
    ST_POPWR = 15'b000000000010000,
    ST_PUT0  = 15'b000000000100000,
    ST_FLRD  = 15'b000000001000000,
    ST_FLWR  = 15'b000000010000000,
    ST_TRRD  = 15'b000000100000000,
    ST_TRWR  = 15'b000001000000000,
    ST_PUT1  = 15'b000010000000000,
    ST_PUT2  = 15'b000100000000000,
    ST_PUSH  = 15'b001000000000000,
    ST_SWEEP = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } ctrl_state_e;

  // Backlog limit clamped to 1..SLOTS-1.
  function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] lim);
    logic [CNT_W-1:0] res;
    if (lim > LIMIT_W'(SLOTS - 1)) begin
      res = CNT_W'(SLOTS - 1);
    end else if (lim == '0) begin
      res = CNT_W'(1);
    end else begin
      res = lim[CNT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fspq_mem.sv
// Small synchronous slot memory, one write and one registered read port.
// Depends on fspq_pkg for widths and the request struct.
`default_nettype none

module fspq_mem (
  input  wire logic                      clk_i,
  input  wire fspq_pkg::mem_req_t        req_i,
  output logic [fspq_pkg::SLOT_W-1:0]    rdata_o
);

  logic [fspq_pkg::SLOT_W-1:0] mem [fspq_pkg::SLOTS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fspq_cfg.sv
// APB-style configuration registers of the frame slot present queue.
// Depends on fspq_pkg for the register indexes and the config struct.
`default_nettype none

module fspq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fspq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [fspq_pkg::DATA_W-1:0]   pwdata,
  output logic      [fspq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output fspq_pkg::cfg_t                     cfg_o
);

  fspq_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fspq_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        fspq_pkg::REG_LEGACY:   cfg_q.legacy_mode         <= pwdata[0];
        fspq_pkg::REG_STEAL:    cfg_q.allow_steal         <= pwdata[0];
        fspq_pkg::REG_REUSE:    cfg_q.allow_reuse         <= pwdata[0];
        fspq_pkg::REG_OLDEST:   cfg_q.prefer_oldest       <= pwdata[0];
        fspq_pkg::REG_DEADLINE: cfg_q.allow_deadline_drop <= pwdata[0];
        fspq_pkg::REG_KEEP:     cfg_q.keep_backlog        <= pwdata[0];
        fspq_pkg::REG_TRIMSKIP: cfg_q.trim_is_skip        <= pwdata[0];
        fspq_pkg::REG_LIMIT:    cfg_q.backlog_limit       <= pwdata[fspq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fspq_pkg::REG_LEGACY:   prdata[0] = cfg_q.legacy_mode;
      fspq_pkg::REG_STEAL:    prdata[0] = cfg_q.allow_steal;
      fspq_pkg::REG_REUSE:    prdata[0] = cfg_q.allow_reuse;
      fspq_pkg::REG_OLDEST:   prdata[0] = cfg_q.prefer_oldest;
      fspq_pkg::REG_DEADLINE: prdata[0] = cfg_q.allow_deadline_drop;
      fspq_pkg::REG_KEEP:     prdata[0] = cfg_q.keep_backlog;
      fspq_pkg::REG_TRIMSKIP: prdata[0] = cfg_q.trim_is_skip;
      fspq_pkg::REG_LIMIT:    prdata[fspq_pkg::LIMIT_W-1:0] = cfg_q.backlog_limit;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fspq_ctrl.sv
// Operation sequencer of the frame slot present queue: decodes a word,
// walks the free ring and the present ring memories and builds the result.
// Depends on fspq_pkg; drives the two fspq_mem instances of the top level.
`default_nettype none

module fspq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fspq_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire fspq_pkg::in_word_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output fspq_pkg::out_word_t                out_data_o,
  output fspq_pkg::mem_req_t                 fmem_req_o,
  input  wire logic [fspq_pkg::SLOT_W-1:0]   fmem_rdata_i,
  output fspq_pkg::mem_req_t                 pmem_req_o,
  input  wire logic [fspq_pkg::SLOT_W-1:0]   pmem_rdata_i
);

  localparam int unsigned SW = fspq_pkg::SLOT_W;
  localparam int unsigned CW = fspq_pkg::CNT_W;

  fspq_pkg::ctrl_state_e state_q, state_d;

  logic [3:0]    mode_q;
  logic [SW-1:0] slot_q;

  // Ring pointers and fill counts.
  logic [SW-1:0] fh_q, ph_q;
  logic [CW-1:0] fc_q, pc_q;

  logic          pend_v_q, prev_v_q, supp_q;
  logic [SW-1:0] pend_s_q, prev_s_q;
  logic [fspq_pkg::ID_WIDTH-1:0] next_id_q;

  // Plan of the current operation, set when it is decoded.
  logic          pop_en_q, pop_free_q, pop_back_q;
  logic          put0_en_q, put1_en_q, put2_en_q;
  logic [SW-1:0] put0_val_q, put1_val_q, put2_val_q;
  logic          flush_en_q, trim_en_q, push_en_q, push_tail_q, sweep_en_q;
  logic [CW-1:0] trim_lim_q;
  logic [SW-1:0] push_val_q;

  // Decoded plan, taken into the plan registers in the decode state.
  logic          pop_en_d, pop_free_d, pop_back_d;
  logic          put0_en_d, put1_en_d, put2_en_d;
  logic [SW-1:0] put0_val_d, put1_val_d, put2_val_d;
  logic          flush_en_d, trim_en_d, push_en_d, push_tail_d, sweep_en_d;
  logic [CW-1:0] trim_lim_d;
  logic [SW-1:0] push_val_d;
  logic [1:0]    status_d;
  logic [SW-1:0] oslot_d;
  logic          reused_d, stolen_d, cnt_en_d, cnt_skip_d;
  logic [CW-1:0] cnt_d;

  // Result under construction.
  logic [1:0]    status_q;
  logic [SW-1:0] oslot_q;
  logic [fspq_pkg::ID_WIDTH-1:0] fid_q;
  logic          reused_q, stolen_q, cnt_en_q, cnt_skip_q;
  logic [CW-1:0] cnt_q;

  logic [SW-1:0] sweep_q;

  logic                 ov_q;
  fspq_pkg::out_word_t  out_q;

  logic          put_en, put_do, push_do, out_load;
  logic [SW-1:0] put_val, back_idx;
  logic [CW-1:0] lim;

  assign back_idx   = ph_q + pc_q[SW-1:0] - SW'(1);
  assign lim        = fspq_pkg::clamp_limit(cfg_i.backlog_limit);
  assign in_ready_o = (state_q == fspq_pkg::ST_IDLE);
  assign out_load   = (state_q == fspq_pkg::ST_OUT) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign push_do    = (state_q == fspq_pkg::ST_PUSH) && push_en_q && (pc_q < fspq_pkg::SLOTS_C);

  // One free-ring put per cycle; a put into a full ring is dropped.
  always_comb begin
    put_en  = 1'b0;
    put_val = pmem_rdata_i;
    case (state_q)
      fspq_pkg::ST_PUT0: begin
        put_en  = put0_en_q;
        put_val = put0_val_q;
      end
      fspq_pkg::ST_PUT1: begin
        put_en  = put1_en_q;
        put_val = put1_val_q;
      end
      fspq_pkg::ST_PUT2: begin
        put_en  = put2_en_q;
        put_val = put2_val_q;
      end
      fspq_pkg::ST_FLWR, fspq_pkg::ST_TRWR: put_en = 1'b1;
      default: ;
    endcase
    put_do = put_en && (fc_q < fspq_pkg::SLOTS_C);
  end

  always_comb begin
    fmem_req_o.raddr = fh_q;
    if (state_q == fspq_pkg::ST_INIT || state_q == fspq_pkg::ST_SWEEP) begin
      fmem_req_o.we    = 1'b1;
      fmem_req_o.waddr = sweep_q;
      fmem_req_o.wdata = sweep_q;
    end else begin
      fmem_req_o.we    = put_do;
      fmem_req_o.waddr = fh_q + fc_q[SW-1:0];
      fmem_req_o.wdata = put_val;
    end
    pmem_req_o.we    = push_do;
    pmem_req_o.waddr = push_tail_q ? (ph_q + pc_q[SW-1:0]) : (ph_q - SW'(1));
    pmem_req_o.wdata = push_val_q;
    if (state_q == fspq_pkg::ST_FLRD ||
        (state_q == fspq_pkg::ST_POPRD && !pop_back_q)) begin
      pmem_req_o.raddr = ph_q;
    end else begin
      pmem_req_o.raddr = back_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fspq_pkg::ST_INIT:  if (sweep_q == fspq_pkg::LAST_SLOT) state_d = fspq_pkg::ST_IDLE;
      fspq_pkg::ST_IDLE:  if (in_valid_i) state_d = fspq_pkg::ST_DEC;
      fspq_pkg::ST_DEC:   state_d = fspq_pkg::ST_POPRD;
      fspq_pkg::ST_POPRD: state_d = pop_en_q ? fspq_pkg::ST_POPWR : fspq_pkg::ST_PUT0;
      fspq_pkg::ST_POPWR: state_d = fspq_pkg::ST_PUT0;
      fspq_pkg::ST_PUT0:  state_d = fspq_pkg::ST_FLRD;
      fspq_pkg::ST_FLRD:
        state_d = (flush_en_q && pc_q != '0) ? fspq_pkg::ST_FLWR : fspq_pkg::ST_TRRD;
      fspq_pkg::ST_FLWR:  state_d = fspq_pkg::ST_FLRD;
      fspq_pkg::ST_TRRD:
        state_d = (trim_en_q && pc_q > trim_lim_q) ? fspq_pkg::ST_TRWR : fspq_pkg::ST_PUT1;
      fspq_pkg::ST_TRWR:  state_d = fspq_pkg::ST_TRRD;
      fspq_pkg::ST_PUT1:  state_d = fspq_pkg::ST_PUT2;
      fspq_pkg::ST_PUT2:  state_d = fspq_pkg::ST_PUSH;
      fspq_pkg::ST_PUSH:  state_d = sweep_en_q ? fspq_pkg::ST_SWEEP : fspq_pkg::ST_OUT;
      fspq_pkg::ST_SWEEP: if (sweep_q == fspq_pkg::LAST_SLOT) state_d = fspq_pkg::ST_OUT;
      fspq_pkg::ST_OUT:   if (out_load) state_d = fspq_pkg::ST_IDLE;
      default:            state_d = fspq_pkg::ST_IDLE;
    endcase
  end

  // Decode of the latched word into the plan and the first result fields.
  always_comb begin
    pop_en_d    = 1'b0;
    pop_free_d  = 1'b0;
    pop_back_d  = 1'b0;
    put0_en_d   = 1'b0;
    put1_en_d   = 1'b0;
    put2_en_d   = 1'b0;
    put0_val_d  = slot_q;
    put1_val_d  = pend_s_q;
    put2_val_d  = prev_s_q;
    flush_en_d  = 1'b0;
    trim_en_d   = 1'b0;
    trim_lim_d  = lim;
    push_en_d   = 1'b0;
    push_tail_d = 1'b0;
    push_val_d  = slot_q;
    sweep_en_d  = 1'b0;
    status_d    = fspq_pkg::STAT_NONE;
    oslot_d     = '0;
    reused_d    = 1'b0;
    stolen_d    = 1'b0;
    cnt_d       = '0;
    cnt_en_d    = 1'b0;
    cnt_skip_d  = 1'b0;
    unique case (mode_q)
      fspq_pkg::MODE_ACQUIRE: begin
        if (fc_q != '0) begin
          pop_en_d   = 1'b1;
          pop_free_d = 1'b1;
        end else if ((cfg_i.legacy_mode || cfg_i.allow_steal) && pc_q != '0) begin
          pop_en_d   = 1'b1;
          pop_back_d = 1'b1;
          stolen_d   = 1'b1;
        end
      end
      fspq_pkg::MODE_PUSH: begin
        if (!cfg_i.legacy_mode) begin
          trim_en_d  = 1'b1;
          trim_lim_d = lim - CW'(1);
          cnt_en_d   = 1'b1;
          cnt_skip_d = cfg_i.trim_is_skip;
        end
        push_en_d = 1'b1;
      end
      fspq_pkg::MODE_RELEASE: begin
        if (fc_q >= fspq_pkg::SLOTS_C) status_d = fspq_pkg::STAT_IGNORED;
        else put0_en_d = 1'b1;
      end
      fspq_pkg::MODE_PRESENT: begin
        if (pc_q == '0) begin
          if ((cfg_i.legacy_mode || (!supp_q && cfg_i.allow_reuse)) && prev_v_q) begin
            oslot_d  = prev_s_q;
            reused_d = 1'b1;
            status_d = fspq_pkg::STAT_SLOT;
          end
        end else begin
          put0_en_d  = prev_v_q;
          put0_val_d = prev_s_q;
          pop_en_d   = 1'b1;
          flush_en_d = 1'b1;
          cnt_en_d   = 1'b1;
        end
      end
      fspq_pkg::MODE_CANDIDATE: begin
        if (pend_v_q) begin
          oslot_d  = pend_s_q;
          status_d = fspq_pkg::STAT_SLOT;
        end else if (pc_q == '0) begin
          if (!supp_q && cfg_i.allow_reuse && prev_v_q) begin
            oslot_d  = prev_s_q;
            reused_d = 1'b1;
            status_d = fspq_pkg::STAT_SLOT;
          end
        end else begin
          pop_en_d   = 1'b1;
          pop_back_d = cfg_i.prefer_oldest;
          flush_en_d = !cfg_i.allow_deadline_drop && !cfg_i.keep_backlog;
          cnt_en_d   = 1'b1;
        end
      end
      fspq_pkg::MODE_REUSE: begin
        if (!supp_q && cfg_i.allow_reuse && prev_v_q) begin
          oslot_d  = prev_s_q;
          reused_d = 1'b1;
          status_d = fspq_pkg::STAT_SLOT;
        end
      end
      fspq_pkg::MODE_COMMIT: begin
        if (!pend_v_q || slot_q != pend_s_q) begin
          status_d = fspq_pkg::STAT_IGNORED;
        end else begin
          put0_en_d  = prev_v_q && (prev_s_q != slot_q);
          put0_val_d = prev_s_q;
          flush_en_d = !cfg_i.keep_backlog;
          trim_en_d  = 1'b1;
          cnt_en_d   = 1'b1;
          cnt_skip_d = cfg_i.trim_is_skip;
        end
      end
      fspq_pkg::MODE_DEFER: begin
        if (!pend_v_q || slot_q != pend_s_q) begin
          status_d = fspq_pkg::STAT_IGNORED;
        end else if (cfg_i.allow_deadline_drop && !cfg_i.prefer_oldest) begin
          put0_en_d  = 1'b1;
          put0_val_d = pend_s_q;
          cnt_d      = CW'(1);
          cnt_en_d   = 1'b1;
        end else begin
          push_en_d   = 1'b1;
          push_val_d  = pend_s_q;
          push_tail_d = !(!cfg_i.allow_deadline_drop && cfg_i.prefer_oldest);
        end
      end
      fspq_pkg::MODE_RESYNC: begin
        flush_en_d = 1'b1;
        put1_en_d  = pend_v_q;
        put2_en_d  = prev_v_q;
      end
      fspq_pkg::MODE_FFWD: begin
        flush_en_d = 1'b1;
        put1_en_d  = pend_v_q;
      end
      fspq_pkg::MODE_CLEAR: sweep_en_d = 1'b1;
      default: status_d = fspq_pkg::STAT_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fspq_pkg::ST_INIT;
      sweep_q   <= '0;
      fh_q      <= '0;
      fc_q      <= fspq_pkg::SLOTS_C;
      ph_q      <= '0;
      pc_q      <= '0;
      pend_v_q  <= 1'b0;
      pend_s_q  <= '0;
      prev_v_q  <= 1'b0;
      prev_s_q  <= '0;
      supp_q    <= 1'b0;
      next_id_q <= fspq_pkg::ID_WIDTH'(1);
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (put_do) fc_q <= fc_q + CW'(1);

      unique case (state_q)
        fspq_pkg::ST_INIT, fspq_pkg::ST_SWEEP: begin
          sweep_q <= sweep_q + SW'(1);
          if (sweep_q == fspq_pkg::LAST_SLOT) begin
            fh_q <= '0;
            fc_q <= fspq_pkg::SLOTS_C;
          end
        end
        fspq_pkg::ST_DEC: begin
          unique case (mode_q)
            fspq_pkg::MODE_PRESENT: begin
              if (pc_q != '0) begin
                prev_v_q <= 1'b0;
                if (!cfg_i.legacy_mode) supp_q <= 1'b0;
              end
            end
            fspq_pkg::MODE_CANDIDATE: begin
              if (!pend_v_q && pc_q != '0) supp_q <= 1'b0;
            end
            fspq_pkg::MODE_COMMIT: begin
              if (!pend_v_q || slot_q != pend_s_q) begin
                if (prev_v_q && slot_q == prev_s_q) supp_q <= 1'b0;
              end else begin
                prev_s_q <= slot_q;
                prev_v_q <= 1'b1;
                pend_v_q <= 1'b0;
                supp_q   <= 1'b0;
              end
            end
            fspq_pkg::MODE_DEFER: begin
              if (pend_v_q && slot_q == pend_s_q &&
                  cfg_i.allow_deadline_drop && !cfg_i.prefer_oldest) begin
                pend_v_q <= 1'b0;
              end
            end
            fspq_pkg::MODE_RESYNC: begin
              pend_v_q <= 1'b0;
              prev_v_q <= 1'b0;
              supp_q   <= 1'b1;
            end
            fspq_pkg::MODE_FFWD: begin
              pend_v_q <= 1'b0;
              supp_q   <= 1'b0;
            end
            fspq_pkg::MODE_CLEAR: begin
              pc_q     <= '0;
              pend_v_q <= 1'b0;
              prev_v_q <= 1'b0;
              supp_q   <= 1'b0;
            end
            default: ;
          endcase
        end
        fspq_pkg::ST_POPWR: begin
          if (pop_free_q) begin
            fh_q <= fh_q + SW'(1);
            fc_q <= fc_q - CW'(1);
          end else begin
            pc_q <= pc_q - CW'(1);
            if (!pop_back_q) ph_q <= ph_q + SW'(1);
          end
          if (mode_q == fspq_pkg::MODE_ACQUIRE) next_id_q <= next_id_q + fspq_pkg::ID_WIDTH'(1);
          if (mode_q == fspq_pkg::MODE_PRESENT) begin
            prev_s_q <= pop_free_q ? fmem_rdata_i : pmem_rdata_i;
            prev_v_q <= 1'b1;
          end
          if (mode_q == fspq_pkg::MODE_CANDIDATE) begin
            pend_s_q <= pmem_rdata_i;
            pend_v_q <= 1'b1;
          end
        end
        fspq_pkg::ST_FLWR: begin
          ph_q <= ph_q + SW'(1);
          pc_q <= pc_q - CW'(1);
        end
        fspq_pkg::ST_TRWR: pc_q <= pc_q - CW'(1);
        fspq_pkg::ST_PUSH: begin
          if (push_do) begin
            pc_q <= pc_q + CW'(1);
            if (!push_tail_q) ph_q <= ph_q - SW'(1);
            if (mode_q == fspq_pkg::MODE_DEFER) pend_v_q <= 1'b0;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload, plan and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == fspq_pkg::ST_IDLE && in_valid_i) begin
      mode_q <= in_data_i.mode;
      slot_q <= in_data_i.slot;
    end

    if (out_load) begin
      out_q.status          <= status_q;
      out_q.out_slot        <= oslot_q;
      out_q.frame_id        <= fid_q;
      out_q.reused_previous <= reused_q;
      out_q.stolen          <= stolen_q;
      out_q.dropped_count   <= (cnt_en_q && !cnt_skip_q) ? cnt_q : '0;
      out_q.skipped_count   <= (cnt_en_q && cnt_skip_q) ? cnt_q : '0;
      out_q.backlog_depth   <= pc_q;
    end

    case (state_q)
      fspq_pkg::ST_DEC: begin
        pop_en_q    <= pop_en_d;
        pop_free_q  <= pop_free_d;
        pop_back_q  <= pop_back_d;
        put0_en_q   <= put0_en_d;
        put1_en_q   <= put1_en_d;
        put2_en_q   <= put2_en_d;
        put0_val_q  <= put0_val_d;
        put1_val_q  <= put1_val_d;
        put2_val_q  <= put2_val_d;
        flush_en_q  <= flush_en_d;
        trim_en_q   <= trim_en_d;
        trim_lim_q  <= trim_lim_d;
        push_en_q   <= push_en_d;
        push_tail_q <= push_tail_d;
        push_val_q  <= push_val_d;
        sweep_en_q  <= sweep_en_d;
        status_q    <= status_d;
        oslot_q     <= oslot_d;
        fid_q       <= '0;
        reused_q    <= reused_d;
        stolen_q    <= stolen_d;
        cnt_q       <= cnt_d;
        cnt_en_q    <= cnt_en_d;
        cnt_skip_q  <= cnt_skip_d;
      end
      fspq_pkg::ST_POPWR: begin
        oslot_q  <= pop_free_q ? fmem_rdata_i : pmem_rdata_i;
        status_q <= fspq_pkg::STAT_SLOT;
        if (mode_q == fspq_pkg::MODE_ACQUIRE) fid_q <= next_id_q;
      end
      fspq_pkg::ST_FLWR, fspq_pkg::ST_TRWR: cnt_q <= cnt_q + CW'(1);
      fspq_pkg::ST_PUSH: begin
        if (push_en_q && pc_q >= fspq_pkg::SLOTS_C) status_q <= fspq_pkg::STAT_IGNORED;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frame_slot_present_queue.sv
// Top level of the frame slot present queue: configuration registers,
// operation sequencer and the two slot ring memories. Depends on fspq_pkg.
`default_nettype none

// A pool of four frame slots moves between a free ring, a present ring
// (newest frame at the front), a pending candidate and the previously shown
// frame. Each accepted word runs one operation and yields exactly one result
// word. After reset the block fills the free ring with slots zero upward
// before it accepts its first word; the clear operation runs the same fill.
// An operation is decoded, may pop a slot from a ring and put one back,
// flushes and trims queued frames (each moved frame is one read of the
// present ring memory followed by one write into the free ring memory), may
// put two more slots back and push a frame and, for clear, refills the free
// ring; a new word can be taken in the cycle after its result enters the
// output register. The result register holds a finished word while the next
// one is processed. The user must write configuration through the APB port
// only while the block is idle; the block itself does not enforce this.

module frame_slot_present_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fspq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [fspq_pkg::DATA_W-1:0]   pwdata,
  output logic      [fspq_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire fspq_pkg::in_word_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output fspq_pkg::out_word_t                out_data_o
);

  fspq_pkg::cfg_t     cfg;
  fspq_pkg::mem_req_t fmem_req, pmem_req;
  logic [fspq_pkg::SLOT_W-1:0] fmem_rdata, pmem_rdata;

  fspq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Free ring: slots available to the renderer, oldest released first.
  fspq_mem u_free_mem (
    .clk_i   (clk_i),
    .req_i   (fmem_req),
    .rdata_o (fmem_rdata)
  );

  // Present ring: queued frames, front entry is the newest.
  fspq_mem u_present_mem (
    .clk_i   (clk_i),
    .req_i   (pmem_req),
    .rdata_o (pmem_rdata)
  );

  fspq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .fmem_req_o   (fmem_req),
    .fmem_rdata_i (fmem_rdata),
    .pmem_req_o   (pmem_req),
    .pmem_rdata_i (pmem_rdata)
  );

  // A result without a slot carries no slot, id or slot flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != fspq_pkg::STAT_SLOT) |->
      (out_data_o.out_slot == '0 && out_data_o.frame_id == '0 &&
       !out_data_o.reused_previous && !out_data_o.stolen))
    else $error("slot fields set on a result without a slot");

  // Drops and skips are never reported together, and depth fits the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.dropped_count == '0 || out_data_o.skipped_count == '0) &&
                     out_data_o.backlog_depth <= fspq_pkg::SLOTS_C))
    else $error("inconsistent drop, skip or depth report");

  // A stolen slot and a reused previous frame are different sources.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.stolen && out_data_o.reused_previous))
    else $error("slot reported as both stolen and reused");

endmodule

`default_nettype wire
